>>> sv/sebd_pkg.sv
// shared types and constants of the spectral energy beat detector
// no dependencies; imported by sebd_band_mem and the core top level
`timescale 1ns / 1ps
`default_nettype none

package sebd_pkg;

	// default number of spectrum bins per frame
	localparam int SEBD_BINS = 256;

	// field widths
	localparam int SAMPLE_W    = 16;
	localparam int SQ_W        = 33;  // (left + right)^2, at most 2^32
	localparam int BAND_AVG_W  = 42;  // per-bin average, 8 fraction bits
	localparam int E_W         = 15;  // (right >> 8)^2, at most 2^14
	localparam int ACC_W       = 23;  // frame energy
	localparam int EAVG_W      = 31;  // frame energy average, 8 fraction bits
	localparam int EAVG_OUT_W  = 30;  // reported frame energy average
	localparam int FRAC_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [ACC_W-1:0]      ACC_MAX      = {ACC_W{1'b1}};
	localparam logic [EAVG_OUT_W-1:0] EAVG_OUT_MAX = {EAVG_OUT_W{1'b1}};

	// register reset values
	localparam logic [3:0] BAND_AVG_SHIFT_RST   = 4'd3;
	localparam logic [3:0] ENERGY_AVG_SHIFT_RST = 4'd3;
	localparam logic [7:0] BEAT_LEVEL_RST       = 8'd24;

	// band beat threshold factor
	localparam int BAND_RATIO = 9;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BAND_AVG_SHIFT   = 2'd0,
		CFG_ENERGY_AVG_SHIFT = 2'd1,
		CFG_BEAT_LEVEL       = 2'd2
	} sebd_cfg_e;

	// one input beat
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_bin;
		logic signed [SAMPLE_W-1:0] right_bin;
		logic                       last_bin;
	} bin_t;

	// one result beat
	typedef struct packed {
		logic                  band_beat;
		logic                  frame_done;
		logic [ACC_W-1:0]      frame_energy;
		logic [EAVG_OUT_W-1:0] frame_avg_energy;
		logic                  frame_beat;
	} res_t;

endpackage

`default_nettype wire

>>> sv/spectral_energy_beat_detector_core.sv
// spectral energy beat detector, top level
// depends on sebd_pkg and sebd_band_mem
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                        moves
// bin       bin_valid bin_ready bin_data   one spectrum bin (left, right, last)
// res       res_valid res_ready res_data   one result per bin
// cfg       cfg_we cfg_idx cfg_data        register write, no handshake
//
// one bin per cycle unless res stalls; bins pass stages 1 to 3, then res_q
// the per-bin average read-modify-write sets the rate: one memory read and one
// write per cycle, with forwarding across the two writes still in flight
// after reset a clearing pass over all BINS entries zeroes the average memory;
// bin_ready stays low meanwhile, cfg writes are taken as ever
// a stalled res blocks bins once stage 3 and the result register both hold a beat

module spectral_energy_beat_detector_core #(
	parameter int BINS = sebd_pkg::SEBD_BINS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             bin_valid,
	output logic                                  bin_ready,
	input  wire sebd_pkg::bin_t                   bin_data,
	output logic                                  res_valid,
	input  wire logic                             res_ready,
	output sebd_pkg::res_t                        res_data,
	input  wire logic                             cfg_we,
	input  wire logic [sebd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [sebd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sebd_pkg::*;

	localparam int AW = $clog2(BINS);
	localparam logic [AW-1:0] LAST_IDX = AW'(BINS - 1);

	// configuration registers
	logic [3:0] band_shift_q;
	logic [3:0] energy_shift_q;
	logic [7:0] beat_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_shift_q   <= BAND_AVG_SHIFT_RST;
			energy_shift_q <= ENERGY_AVG_SHIFT_RST;
			beat_level_q   <= BEAT_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_BAND_AVG_SHIFT:   band_shift_q   <= cfg_data[3:0];
				CFG_ENERGY_AVG_SHIFT: energy_shift_q <= cfg_data[3:0];
				CFG_BEAT_LEVEL:       beat_level_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, res_vld_q;
	logic adv, bin_fire, clr_busy;

	assign adv       = !vld_s3 || !res_vld_q || res_ready;
	assign bin_ready = adv && !clr_busy;
	assign bin_fire  = bin_valid && bin_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= bin_fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// bin index counter
	logic [AW-1:0] bin_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q <= '0;
		end else if (bin_fire) begin
			if (bin_data.last_bin || bin_cnt_q == LAST_IDX) begin
				bin_cnt_q <= '0;
			end else begin
				bin_cnt_q <= bin_cnt_q + 1'b1;
			end
		end
	end

	// per-bin average memory
	logic [BAND_AVG_W-1:0] rd_avg;
	logic [BAND_AVG_W-1:0] avg_new;
	logic [AW-1:0]         idx_s2;
	logic                  mem_we;

	assign mem_we = adv && vld_s2;

	sebd_band_mem #(
		.BINS(BINS)
	) u_band_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (bin_fire),
		.rd_addr  (bin_cnt_q),
		.rd_data  (rd_avg),
		.wr_en    (mem_we),
		.wr_addr  (idx_s2),
		.wr_data  (avg_new),
		.clr_busy (clr_busy)
	);

	// stage 1: input register
	logic signed [SAMPLE_W-1:0] left_s1, right_s1;
	logic                       last_s1;
	logic [AW-1:0]              idx_s1;

	always_ff @(posedge clk) begin
		if (bin_fire) begin
			left_s1  <= bin_data.left_bin;
			right_s1 <= bin_data.right_bin;
			last_s1  <= bin_data.last_bin;
			idx_s1   <= bin_cnt_q;
		end
	end

	// last write, made as the stage 1 bin was read, so missing from its read data
	logic                  hold_vld_q;
	logic [AW-1:0]         hold_idx_q;
	logic [BAND_AVG_W-1:0] hold_avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
		end else if (adv) begin
			hold_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hold_idx_q <= idx_s2;
			hold_avg_q <= avg_new;
		end
	end

	// stage 1 logic: squares and average forwarding
	logic signed [SAMPLE_W:0]     sum_s1;
	logic signed [2*SAMPLE_W+1:0] sq_full;
	logic signed [7:0]            r8_s1;
	logic signed [15:0]           e_full;
	logic [BAND_AVG_W-1:0]        old_avg_s1;

	assign sum_s1  = 17'(left_s1) + 17'(right_s1);
	assign sq_full = 34'(sum_s1) * 34'(sum_s1);
	assign r8_s1   = right_s1[15:8];
	assign e_full  = 16'(r8_s1) * 16'(r8_s1);

	always_comb begin
		priority if (vld_s2 && idx_s2 == idx_s1) begin
			old_avg_s1 = avg_new;
		end else if (hold_vld_q && hold_idx_q == idx_s1) begin
			old_avg_s1 = hold_avg_q;
		end else begin
			old_avg_s1 = rd_avg;
		end
	end

	// stage 2 registers
	logic [SQ_W-1:0]       sq_s2;
	logic [BAND_AVG_W-1:0] old_avg_s2;
	logic [E_W-1:0]        e_s2;
	logic                  last_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s2      <= sq_full[SQ_W-1:0];
			old_avg_s2 <= old_avg_s1;
			e_s2       <= e_full[E_W-1:0];
			last_s2    <= last_s1;
			idx_s2     <= idx_s1;
		end
	end

	// stage 2 logic: band average, frame energy and its average
	logic [BAND_AVG_W-1:0] band_x;
	logic [ACC_W-1:0]      acc_q;
	logic [ACC_W:0]        acc_sum;
	logic [ACC_W-1:0]      acc_new;
	logic [EAVG_W-1:0]     eavg_q;
	logic [EAVG_W-1:0]     eavg_x;
	logic [EAVG_W-1:0]     eavg_new;

	assign band_x   = {1'b0, sq_s2, {FRAC_W{1'b0}}};
	assign avg_new  = old_avg_s2 - (old_avg_s2 >> band_shift_q) + (band_x >> band_shift_q);
	assign acc_sum  = {1'b0, acc_q} + (ACC_W + 1)'(e_s2);
	assign acc_new  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
	assign eavg_x   = {acc_new, {FRAC_W{1'b0}}};
	assign eavg_new = eavg_q - (eavg_q >> energy_shift_q) + (eavg_x >> energy_shift_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			eavg_q <= '0;
		end else if (adv && vld_s2) begin
			acc_q <= last_s2 ? '0 : acc_new;
			if (last_s2) begin
				eavg_q <= eavg_new;
			end
		end
	end

	// stage 3 registers
	logic [SQ_W-1:0]       sq_s3;
	logic [BAND_AVG_W-1:0] avg_s3;
	logic                  last_s3;
	logic [ACC_W-1:0]      acc_s3;
	logic [EAVG_W-1:0]     eavg_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3   <= sq_s2;
			avg_s3  <= avg_new;
			last_s3 <= last_s2;
			acc_s3  <= acc_new;
			eavg_s3 <= eavg_new;
		end
	end

	// stage 3 logic: beat tests and result formatting
	localparam int AVG9_W = BAND_AVG_W + 4;
	localparam int LVL_W  = EAVG_W + 8;

	logic [AVG9_W-1:0] avg9;
	logic [AVG9_W-1:0] band_cmp;
	logic [LVL_W-1:0]  lvl_avg;
	logic [LVL_W-1:0]  e_cmp;
	res_t              res_d;

	assign avg9     = AVG9_W'(avg_s3) * AVG9_W'(BAND_RATIO);
	assign band_cmp = AVG9_W'({sq_s3, {FRAC_W{1'b0}}});
	assign lvl_avg  = LVL_W'(beat_level_q) * LVL_W'(eavg_s3);
	assign e_cmp    = LVL_W'({acc_s3, 12'b0});

	always_comb begin
		res_d            = '0;
		res_d.band_beat  = band_cmp > avg9;
		if (last_s3) begin
			res_d.frame_done       = 1'b1;
			res_d.frame_energy     = acc_s3;
			res_d.frame_avg_energy = eavg_s3[EAVG_W-1] ? EAVG_OUT_MAX
			                                           : eavg_s3[EAVG_OUT_W-1:0];
			res_d.frame_beat       = e_cmp > lvl_avg;
		end
	end

	// result register
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv && vld_s3) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_vld_q;
	assign res_data  = res_q;

`ifndef SYNTHESIS
	// a frame ends: the next bin starts at index zero
	a_cnt_restart: assert property (@(posedge clk) disable iff (!arst_n)
		bin_fire && bin_data.last_bin |=> bin_cnt_q == '0)
		else $error("bin counter did not restart after last bin");

	// frame fields stay clear on bins that do not end a frame
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.frame_done |->
			res_data.frame_energy == '0 && res_data.frame_avg_energy == '0 &&
			!res_data.frame_beat)
		else $error("frame fields set on a bin that is not last");

	// no bin taken while the memory is still being cleared
	a_no_bin_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |=> !vld_s1 || !$past(clr_busy))
		else $error("bin accepted during clearing pass");
`endif

endmodule

`default_nettype wire

>>> sv/sebd_band_mem.sv
// per-bin average memory: one write port, one registered read port
// clears itself after reset, one entry per cycle; uses sebd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sebd_band_mem #(
	parameter int BINS = sebd_pkg::SEBD_BINS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               rd_en,
	input  wire logic [$clog2(BINS)-1:0]            rd_addr,
	output logic      [sebd_pkg::BAND_AVG_W-1:0]    rd_data,
	input  wire logic                               wr_en,
	input  wire logic [$clog2(BINS)-1:0]            wr_addr,
	input  wire logic [sebd_pkg::BAND_AVG_W-1:0]    wr_data,
	output logic                                    clr_busy
);
	import sebd_pkg::*;

	localparam int AW = $clog2(BINS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(BINS - 1);

	logic [BAND_AVG_W-1:0] mem [BINS];
	logic [AW-1:0]         clr_cnt_q;
	logic                  clr_busy_q;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// write port, shared with the sweep
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// testbench of spectral_energy_beat_detector_core: random and directed spectrum bins,
// results checked against a bit-exact predictor in a scoreboard class
// depends on sebd_pkg and the core RTL
`timescale 1ns / 1ps

module tb_top;
	import sebd_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 4;
	localparam int SETTLE_CYCLES  = 10;
	localparam int RX_HOLD_AT     = 150;
	localparam int RX_HOLD_CYCLES = 120;
	localparam int LONG_FRAME     = 270;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_BINS     = 16;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

	// scoreboard: predicts one result beat per bin and checks arrivals in order
	class beat_board;
		logic [BAND_AVG_W-1:0] band_avg [SEBD_BINS];
		logic [ACC_W-1:0]      energy_sum;
		logic [EAVG_W-1:0]     energy_avg;
		int unsigned           bin_idx;
		logic [3:0]            band_shift;
		logic [3:0]            energy_shift;
		logic [7:0]            level;
		res_t                  res_due [$];
		int                    errors;

		function new();
			foreach (band_avg[i]) band_avg[i] = '0;
			energy_sum   = '0;
			energy_avg   = '0;
			bin_idx      = 0;
			band_shift   = BAND_AVG_SHIFT_RST;
			energy_shift = ENERGY_AVG_SHIFT_RST;
			level        = BEAT_LEVEL_RST;
			errors       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BAND_AVG_SHIFT:   band_shift = data[3:0];
				CFG_ENERGY_AVG_SHIFT: energy_shift = data[3:0];
				CFG_BEAT_LEVEL:       level = data;
				default: ;
			endcase
		endfunction

		// accepted bin: update the averages and queue the result it causes
		function void take_bin(bin_t b);
			logic signed [SAMPLE_W-1:0] lft, rgt;
			logic signed [SAMPLE_W:0]   sum;
			longint                     sum_l;
			logic [63:0]                sq8, old_avg, new_avg, acc, eavg;
			int                         r8;
			res_t                       r;
			lft = b.left_bin;
			rgt = b.right_bin;
			sum = lft + rgt;
			sum_l = sum;
			sq8 = 64'(sum_l * sum_l) << FRAC_W;

			// per-bin moving average and band test
			old_avg = 64'(band_avg[bin_idx]);
			new_avg = old_avg - (old_avg >> band_shift) + (sq8 >> band_shift);
			band_avg[bin_idx] = new_avg[BAND_AVG_W-1:0];
			r = '0;
			r.band_beat = (sq8 > 64'(BAND_RATIO) * new_avg);

			// frame energy, saturating
			r8 = rgt >>> 8;
			acc = 64'(energy_sum) + 64'(r8 * r8);
			if (acc > 64'(ACC_MAX))
				acc = 64'(ACC_MAX);
			energy_sum = acc[ACC_W-1:0];

			// end of frame: energy average and frame test
			if (b.last_bin) begin
				eavg = 64'(energy_avg) - (64'(energy_avg) >> energy_shift)
					+ ((acc << FRAC_W) >> energy_shift);
				energy_avg = eavg[EAVG_W-1:0];
				r.frame_done = 1'b1;
				r.frame_energy = acc[ACC_W-1:0];
				r.frame_avg_energy = (eavg > 64'(EAVG_OUT_MAX)) ? EAVG_OUT_MAX
					: eavg[EAVG_OUT_W-1:0];
				r.frame_beat = (acc * 64'd4096 > 64'(level) * eavg);
				energy_sum = '0;
				bin_idx = 0;
			end else begin
				bin_idx = (bin_idx + 1) % SEBD_BINS;
			end
			res_due.push_back(r);
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s expected %0h got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_res(res_t got);
			res_t want;
			if (res_due.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				errors++;
				return;
			end
			want = res_due.pop_front();
			cmp_field("band_beat", 64'(want.band_beat), 64'(got.band_beat));
			cmp_field("frame_done", 64'(want.frame_done), 64'(got.frame_done));
			cmp_field("frame_energy", 64'(want.frame_energy), 64'(got.frame_energy));
			cmp_field("frame_avg_energy", 64'(want.frame_avg_energy),
				64'(got.frame_avg_energy));
			cmp_field("frame_beat", 64'(want.frame_beat), 64'(got.frame_beat));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  bin_valid = 1'b0;
	logic                  bin_ready;
	bin_t                  bin_data = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_t                  res_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	beat_board board = new();
	bit        tx_burst = 1'b0;
	bit        rx_burst = 1'b0;
	int        res_count = 0;

	spectral_energy_beat_detector_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.bin_ready (bin_ready),
		.bin_data  (bin_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	// clock
	always #(CLK_HALF) clk = ~clk;

	// run limit
	initial begin
		#(64'd5_000_000);
		$display("FAIL");
		$finish;
	end

	function automatic bin_t mk_bin(logic [15:0] l, logic [15:0] r, logic last);
		bin_t b;
		b.left_bin  = l;
		b.right_bin = r;
		b.last_bin  = last;
		return b;
	endfunction

	// sample mix: extremes, near zero, around the shift boundary, full range
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 16'h7fff;
			1:       return 16'h8000;
			2:       return 16'h0000;
			3:       return 16'($urandom_range(0, 31)) - 16'd16;
			4:       return 16'($urandom_range(0, 511)) - 16'd256;
			default: return 16'($urandom);
		endcase
	endfunction

	// offer one bin beat, called at a rising edge; returns after acceptance
	task automatic send_bin(input bin_t b);
		int gap;
		if ($urandom_range(0, 15) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			bin_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bin_data  <= b;
		bin_valid <= 1'b1;
		@(posedge clk);
		while (!bin_ready) @(posedge clk);
		board.take_bin(b);
	endtask

	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++)
			send_bin(mk_bin(pick_sample(), pick_sample(), i == len - 1));
	endtask

	// stop offering and let every expected result come back
	task automatic drain();
		bin_valid <= 1'b0;
		while (board.res_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// junk in the upper bits of the shift writes must be ignored
	task automatic set_regs(input logic [3:0] bsh, input logic [3:0] esh, input logic [7:0] lvl,
		input bit poke_unused);
		write_reg(CFG_BAND_AVG_SHIFT, {4'($urandom), bsh});
		write_reg(CFG_ENERGY_AVG_SHIFT, {4'($urandom), esh});
		write_reg(CFG_BEAT_LEVEL, lvl);
		if (poke_unused)
			write_reg(CFG_NO_REG, 8'($urandom));
		cfg_we <= 1'b0;
	endtask

	// result side: random ready gaps, one long hold-off
	initial begin
		int gap;
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			board.check_res(res_data);
			res_count++;
			if (res_count == RX_HOLD_AT) begin
				res_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// stimulus
	initial begin
		int sent;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// slow averages first, so fresh bins and the first frame see a zero average
		write_reg(CFG_BAND_AVG_SHIFT, 8'h0f);
		write_reg(CFG_ENERGY_AVG_SHIFT, 8'h0f);
		cfg_we <= 1'b0;
		send_bin(mk_bin(16'd1, 16'd0, 1'b0));
		send_bin(mk_bin(16'd0, 16'd0, 1'b0));
		send_bin(mk_bin(16'd3, 16'hffff, 1'b0));
		send_bin(mk_bin(16'd0, 16'hff00, 1'b1));
		send_bin(mk_bin(16'h7fff, 16'h7fff, 1'b1));
		drain();

		// field extremes, fast averages, highest level
		set_regs(4'd0, 4'd0, 8'd255, 1'b0);
		send_bin(mk_bin(16'h8000, 16'h8000, 1'b0));
		send_bin(mk_bin(16'h7fff, 16'h7fff, 1'b0));
		send_bin(mk_bin(16'h7fff, 16'h8000, 1'b0));
		send_bin(mk_bin(16'h8000, 16'h7fff, 1'b0));
		send_bin(mk_bin(16'h0000, 16'h00ff, 1'b0));
		send_bin(mk_bin(16'h0000, 16'hffff, 1'b0));
		send_bin(mk_bin(16'h0000, 16'h0100, 1'b0));
		send_bin(mk_bin(16'hffff, 16'h8000, 1'b0));
		send_bin(mk_bin(16'h8000, 16'h0000, 1'b1));
		send_bin(mk_bin(16'd100, 16'd100, 1'b1));
		send_bin(mk_bin(16'd100, 16'd100, 1'b1));
		send_bin(mk_bin(16'h0000, 16'h0000, 1'b1));
		drain();

		// one frame past BINS at full right value: counter wraps and the
		// reported average saturates
		set_regs(4'd3, 4'd0, 8'd16, 1'b0);
		for (int i = 0; i < LONG_FRAME; i++)
			send_bin(mk_bin(pick_sample(), 16'h8000, i == LONG_FRAME - 1));
		drain();

		// random frames under several settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: set_regs(BAND_AVG_SHIFT_RST, ENERGY_AVG_SHIFT_RST, BEAT_LEVEL_RST, 1'b0);
				1: set_regs(4'd0, 4'd0, 8'd0, 1'b0);
				2: set_regs(4'd15, 4'd15, 8'd255, 1'b0);
				default: set_regs(4'($urandom), 4'($urandom), 8'($urandom), ph == 3);
			endcase
			sent = 0;
			while (sent < PHASE_BINS) begin
				int len;
				len = $urandom_range(1, 12);
				send_frame(len);
				sent += len;
			end
			drain();
		end

		if (board.errors == 0 && board.res_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
